@@ rtl/core/cdt_pkg.sv @@
`default_nettype none

package cdt_pkg;

  // Field and register widths
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned ENC_CNT_W = 4;

  // Limits and reset values
  localparam logic [FIELD_W-1:0] MIN_SEC_LIMIT = FIELD_W'(59);
  localparam logic [TICK_W-1:0]  LONG_PRESS_RST = TICK_W'(30);
  localparam logic [TICK_W-1:0]  BEEP_TOGGLES_RST = TICK_W'(6);
  localparam logic [FIELD_W-1:0] MAX_HOURS_RST = FIELD_W'(47);

  typedef enum logic [1:0] {
    CMD_ENC = 2'd0,
    CMD_BTN = 2'd1,
    CMD_SEC = 2'd2,
    CMD_OUT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_VIEW    = 2'd0,
    MODE_SET_SEC = 2'd1,
    MODE_SET_MIN = 2'd2,
    MODE_SET_HRS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_BEEP_TOGGLES = 2'd1,
    CFG_MAX_HOURS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0]  long_press_ticks;
    logic [TICK_W-1:0]  beep_toggles;
    logic [FIELD_W-1:0] max_hours;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] enc_pins;
    logic       button_down;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] hours;
    logic [FIELD_W-1:0] minutes;
    logic [FIELD_W-1:0] seconds;
    logic [1:0]         mode;
    logic               running;
    logic               relay_on;
    logic               led_on;
    logic               buzzer_on;
  } result_t;

  // Quadrature sequence 0 -> 2 -> 3 -> 1 -> 0 counts up
  function automatic logic [1:0] enc_up_to(input logic [1:0] prev);
    logic [1:0] nxt;
    case (prev)
      2'd0:    nxt = 2'd2;
      2'd1:    nxt = 2'd0;
      2'd2:    nxt = 2'd3;
      default: nxt = 2'd1;
    endcase
    return nxt;
  endfunction

  function automatic logic [1:0] enc_down_to(input logic [1:0] prev);
    logic [1:0] nxt;
    case (prev)
      2'd0:    nxt = 2'd1;
      2'd1:    nxt = 2'd3;
      2'd2:    nxt = 2'd0;
      default: nxt = 2'd2;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cdt_if.sv @@
`default_nettype none

// Input request channel
interface cdt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] enc_pins;
  logic       button_down;

  modport source (output valid, cmd, enc_pins, button_down, input ready);
  modport sink   (input valid, cmd, enc_pins, button_down, output ready);
endinterface

// Result channel
interface cdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [cdt_pkg::FIELD_W-1:0] hours;
  logic [cdt_pkg::FIELD_W-1:0] minutes;
  logic [cdt_pkg::FIELD_W-1:0] seconds;
  logic [1:0]                  mode;
  logic                        running;
  logic                        relay_on;
  logic                        led_on;
  logic                        buzzer_on;

  modport source (output valid, hours, minutes, seconds, mode, running, relay_on,
                  led_on, buzzer_on, input ready);
  modport sink   (input valid, hours, minutes, seconds, mode, running, relay_on,
                  led_on, buzzer_on, output ready);
endinterface

// Register write channel
interface cdt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cdt_pkg::CFG_IDX_W-1:0] index;
  logic [cdt_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdt_cfg.sv @@
`default_nettype none

module cdt_cfg (
  input  wire             clk_i,
  input  wire             rst_ni,
  cdt_cfg_if.sink         cfg_i,
  output cdt_pkg::cfg_t   cfg_o
);

  cdt_pkg::cfg_t cfg_q;
  logic          wr_en;

  // Always take a write request
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Decode the register index; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= cdt_pkg::LONG_PRESS_RST;
      cfg_q.beep_toggles     <= cdt_pkg::BEEP_TOGGLES_RST;
      cfg_q.max_hours        <= cdt_pkg::MAX_HOURS_RST;
    end else if (wr_en) begin
      unique case (cdt_pkg::cfg_idx_e'(cfg_i.index))
        cdt_pkg::CFG_LONG_PRESS:   cfg_q.long_press_ticks <= cfg_i.data;
        cdt_pkg::CFG_BEEP_TOGGLES: cfg_q.beep_toggles     <= cfg_i.data;
        cdt_pkg::CFG_MAX_HOURS:    cfg_q.max_hours <= cfg_i.data[cdt_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/cdt_engine.sv @@
`default_nettype none

module cdt_engine (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    fire_i,
  input  wire cdt_pkg::item_t    item_i,
  input  wire cdt_pkg::cfg_t     cfg_i,
  output cdt_pkg::result_t       res_o
);

  localparam int unsigned FW = cdt_pkg::FIELD_W;
  localparam int unsigned TW = cdt_pkg::TICK_W;
  localparam int unsigned CW = cdt_pkg::ENC_CNT_W;

  logic [FW-1:0] hours_q, hours_d, minutes_q, minutes_d, seconds_q, seconds_d;
  logic [FW-1:0] pre_h_q, pre_h_d, pre_m_q, pre_m_d, pre_s_q, pre_s_d;
  cdt_pkg::mode_e  mode_q, mode_d;
  cdt_pkg::press_e event_q, event_d;
  logic run_q, run_d, relay_q, relay_d, led_q, led_d, blink_q, blink_d;
  logic buzz_q, buzz_d, alarm_q, alarm_d, held_q, held_d;
  logic [TW-1:0] toggles_q, toggles_d, hold_q, hold_d;
  logic [1:0]    enc_prev_q, enc_prev_d;
  logic signed [CW-1:0] enc_cnt_q, enc_cnt_d, enc_cnt_n;

  logic          time_zero;
  logic [FW-1:0] sel_v, lim_v, up_v, down_v, step_v;
  logic [FW-1:0] dec_h, dec_m, dec_s;
  logic          dec_zero;

  assign time_zero = ~|{hours_q, minutes_q, seconds_q};

  // Field picked by the set mode, with its wrap limit
  assign sel_v = (mode_q == cdt_pkg::MODE_SET_SEC) ? seconds_q :
                 (mode_q == cdt_pkg::MODE_SET_MIN) ? minutes_q : hours_q;
  assign lim_v = (mode_q == cdt_pkg::MODE_SET_HRS) ? cfg_i.max_hours
                                                   : cdt_pkg::MIN_SEC_LIMIT;
  assign up_v   = (({1'b0, sel_v} + (FW+1)'(1)) > {1'b0, lim_v}) ? '0 : sel_v + FW'(1);
  assign down_v = (sel_v == '0) ? lim_v : sel_v - FW'(1);

  // Count encoder steps
  always_comb begin
    if (item_i.enc_pins == cdt_pkg::enc_up_to(enc_prev_q)) begin
      enc_cnt_n = enc_cnt_q + CW'(signed'(1));
    end else if (item_i.enc_pins == cdt_pkg::enc_down_to(enc_prev_q)) begin
      enc_cnt_n = enc_cnt_q - CW'(signed'(1));
    end else begin
      enc_cnt_n = enc_cnt_q;
    end
  end
  assign step_v = (enc_cnt_n > 0) ? up_v : down_v;

  // Count down one second, holding at zero
  always_comb begin
    dec_h = hours_q;
    dec_m = minutes_q;
    dec_s = seconds_q;
    if (seconds_q != '0) begin
      dec_s = seconds_q - FW'(1);
    end else if (minutes_q != '0) begin
      dec_m = minutes_q - FW'(1);
      dec_s = cdt_pkg::MIN_SEC_LIMIT;
    end else if (hours_q != '0) begin
      dec_h = hours_q - FW'(1);
      dec_m = cdt_pkg::MIN_SEC_LIMIT;
      dec_s = cdt_pkg::MIN_SEC_LIMIT;
    end
  end
  assign dec_zero = ~|{dec_h, dec_m, dec_s};

  // Next state for one request
  always_comb begin
    hours_d = hours_q;  minutes_d = minutes_q;  seconds_d = seconds_q;
    pre_h_d = pre_h_q;  pre_m_d = pre_m_q;      pre_s_d = pre_s_q;
    mode_d = mode_q;    event_d = event_q;
    run_d = run_q;      relay_d = relay_q;      led_d = led_q;
    blink_d = blink_q;  buzz_d = buzz_q;        alarm_d = alarm_q;
    held_d = held_q;    toggles_d = toggles_q;  hold_d = hold_q;
    enc_prev_d = enc_prev_q;
    enc_cnt_d = enc_cnt_q;
    unique case (cdt_pkg::cmd_e'(item_i.cmd))
      cdt_pkg::CMD_ENC: begin
        enc_prev_d = item_i.enc_pins;
        if (enc_cnt_n > CW'(signed'(3)) || enc_cnt_n < -CW'(signed'(3))) begin
          enc_cnt_d = '0;
          case (mode_q)
            cdt_pkg::MODE_SET_SEC: seconds_d = step_v;
            cdt_pkg::MODE_SET_MIN: minutes_d = step_v;
            cdt_pkg::MODE_SET_HRS: hours_d   = step_v;
            default: ;
          endcase
        end else begin
          enc_cnt_d = enc_cnt_n;
        end
      end
      cdt_pkg::CMD_BTN: begin
        if (!held_q) begin
          if (item_i.button_down) begin
            held_d = 1'b1;
            hold_d = '0;
            if (event_q == cdt_pkg::EV_NONE) event_d = cdt_pkg::EV_SHORT;
          end else if (event_q != cdt_pkg::EV_NONE) begin
            // Act on the finished press
            event_d = cdt_pkg::EV_NONE;
            if (event_q == cdt_pkg::EV_SHORT) begin
              if (mode_q != cdt_pkg::MODE_VIEW) begin
                mode_d = cdt_pkg::mode_e'(mode_q + 2'd1);
              end else if (!time_zero) begin
                run_d   = ~run_q;
                blink_d = ~blink_q;
                relay_d = ~relay_q;
              end
            end else begin
              case (mode_q)
                cdt_pkg::MODE_VIEW: if (!run_q) mode_d = cdt_pkg::MODE_SET_SEC;
                cdt_pkg::MODE_SET_SEC: begin
                  hours_d = pre_h_q;  minutes_d = pre_m_q;  seconds_d = pre_s_q;
                end
                cdt_pkg::MODE_SET_HRS: begin
                  pre_h_d = hours_q;  pre_m_d = minutes_q;  pre_s_d = seconds_q;
                end
                default: ;
              endcase
            end
          end
        end else if (item_i.button_down) begin
          if (hold_q < cfg_i.long_press_ticks) begin
            hold_d = hold_q + TW'(1);
          end else begin
            hold_d  = '0;
            event_d = cdt_pkg::EV_LONG;
          end
        end else begin
          held_d = 1'b0;
          hold_d = '0;
        end
      end
      cdt_pkg::CMD_SEC: begin
        if (run_q) begin
          led_d     = ~led_q;
          hours_d   = dec_h;
          minutes_d = dec_m;
          seconds_d = dec_s;
          if (dec_zero) begin
            relay_d = 1'b0;
            blink_d = 1'b0;
            alarm_d = 1'b1;
            run_d   = 1'b0;
          end
        end
      end
      default: begin
        if (!blink_q) led_d = 1'b0;
        if (alarm_q && toggles_q != '0) begin
          toggles_d = toggles_q - TW'(1);
          buzz_d    = ~buzz_q;
        end else begin
          buzz_d    = 1'b0;
          toggles_d = cfg_i.beep_toggles;
          alarm_d   = 1'b0;
        end
      end
    endcase
  end

  // Advance the state on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q <= '0;  minutes_q <= '0;  seconds_q <= '0;
      pre_h_q <= '0;  pre_m_q <= '0;    pre_s_q <= '0;
      mode_q  <= cdt_pkg::MODE_VIEW;
      event_q <= cdt_pkg::EV_NONE;
      run_q <= 1'b0;  relay_q <= 1'b0;  led_q <= 1'b0;
      blink_q <= 1'b0;  buzz_q <= 1'b0;  alarm_q <= 1'b0;
      held_q <= 1'b0;
      toggles_q <= cdt_pkg::BEEP_TOGGLES_RST;
      hold_q <= '0;
      enc_prev_q <= '0;
      enc_cnt_q <= '0;
    end else if (fire_i) begin
      hours_q <= hours_d;  minutes_q <= minutes_d;  seconds_q <= seconds_d;
      pre_h_q <= pre_h_d;  pre_m_q <= pre_m_d;      pre_s_q <= pre_s_d;
      mode_q  <= mode_d;
      event_q <= event_d;
      run_q <= run_d;  relay_q <= relay_d;  led_q <= led_d;
      blink_q <= blink_d;  buzz_q <= buzz_d;  alarm_q <= alarm_d;
      held_q <= held_d;
      toggles_q <= toggles_d;
      hold_q <= hold_d;
      enc_prev_q <= enc_prev_d;
      enc_cnt_q <= enc_cnt_d;
    end
  end

  // Result shows the state after the request
  assign res_o.hours     = hours_d;
  assign res_o.minutes   = minutes_d;
  assign res_o.seconds   = seconds_d;
  assign res_o.mode      = mode_d;
  assign res_o.running   = run_d;
  assign res_o.relay_on  = relay_d;
  assign res_o.led_on    = led_d;
  assign res_o.buzzer_on = buzz_d;

endmodule

`default_nettype wire

@@ rtl/core/countdown_timer_with_encoder_setting_core.sv @@
// A request is held in the input register, then moved into the result register.
// Throughput: one request per cycle while results drain; a held result lets one
// more request into the input register, then stalls the input.
// Reset (rst_ni low, asynchronous) clears the time, preset and all flags,
// sets normal mode and loads the registers with 30, 6 and 47.
`default_nettype none

module countdown_timer_with_encoder_setting_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  cdt_in_if.sink     in_i,
  cdt_out_if.source  out_o,
  cdt_cfg_if.sink    cfg_i
);

  cdt_pkg::cfg_t    cfg;
  cdt_pkg::item_t   item_q;
  cdt_pkg::result_t res_d, res_q;
  logic             s1_valid_q, out_valid_q;
  logic             s1_fire, in_ready, in_accept;

  cdt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Move a request on when the result register is free or being drained
  assign s1_fire   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready  = !s1_valid_q || s1_fire;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.cmd         <= in_i.cmd;
      item_q.enc_pins    <= in_i.enc_pins;
      item_q.button_down <= in_i.button_down;
    end
  end

  cdt_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hours     = res_q.hours;
  assign out_o.minutes   = res_q.minutes;
  assign out_o.seconds   = res_q.seconds;
  assign out_o.mode      = res_q.mode;
  assign out_o.running   = res_q.running;
  assign out_o.relay_on  = res_q.relay_on;
  assign out_o.led_on    = res_q.led_on;
  assign out_o.buzzer_on = res_q.buzzer_on;

endmodule

`default_nettype wire

@@ rtl/core/cdt_checker.sv @@
`default_nettype none

module cdt_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire [cdt_pkg::FIELD_W-1:0] minutes_i,
  input wire [cdt_pkg::FIELD_W-1:0] seconds_i,
  input wire [1:0]                  mode_i,
  input wire                        running_i,
  input wire                        relay_on_i
);

  // A stalled result keeps its minutes and seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(minutes_i) && $stable(seconds_i))
    else $error("stalled result changed");

  // Minutes and seconds never pass their limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> minutes_i <= cdt_pkg::MIN_SEC_LIMIT &&
                    seconds_i <= cdt_pkg::MIN_SEC_LIMIT)
    else $error("minutes or seconds out of range");

  // Relay follows the run flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> running_i == relay_on_i)
    else $error("relay and running disagree");

  // No countdown while a field is being set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i != cdt_pkg::MODE_VIEW |-> !running_i)
    else $error("running in set mode");

endmodule

bind countdown_timer_with_encoder_setting_core cdt_checker u_cdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .minutes_i   (out_o.minutes),
  .seconds_i   (out_o.seconds),
  .mode_i      (out_o.mode),
  .running_i   (out_o.running),
  .relay_on_i  (out_o.relay_on)
);

`default_nettype wire
